// File: src/obrf_pkg.sv
// Shared types and constants for the overwriting byte ring FIFO.
`default_nettype none
package obrf_pkg;

    localparam int DEFAULT_SLOTS = 256;
    localparam int BYTE_W        = 8;
    localparam int OP_W          = 2;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] offset;
        logic [BYTE_W-1:0] value;
        logic [OP_W-1:0]   opcode;
    } item_t;

    typedef struct packed {
        logic              overwrote;
        logic              is_full;
        logic              is_empty;
        logic [BYTE_W-1:0] used_count;
        logic              data_valid;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage
`default_nettype wire

// File: src/obrf_ring.sv
// Ring pointers, byte store and per-transaction result registers.
`default_nettype none
module obrf_ring
    import obrf_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] capacity,
    input  wire logic              step,
    input  wire item_t             item,
    output result_t                result
);

    localparam int RING_MAX = (SLOTS < 256) ? SLOTS : 256;
    localparam int POS_W    = $clog2(RING_MAX);
    localparam int CNT_W    = POS_W + 1;
    localparam int IDX_W    = BYTE_W + 1;

    logic [BYTE_W-1:0] slot_mem [RING_MAX];

    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [POS_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              hit_reg, hit_next;
    logic [POS_W-1:0]  used_reg, used_next;
    logic              empty_reg, full_reg;
    logic              over_reg, over_next;

    logic [POS_W-1:0]  ecap;
    logic [CNT_W-1:0]  rs;
    logic [POS_W-1:0]  used_now;
    logic [POS_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  peek_idx;
    logic              mem_we;

    function automatic logic [POS_W-1:0] used_of(
        input logic [POS_W-1:0] rd,
        input logic [POS_W-1:0] wr,
        input logic [CNT_W-1:0] size
    );
        logic [CNT_W-1:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd) begin
            diff = diff + size;
        end
        return diff[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] adv(
        input logic [POS_W-1:0] p,
        input logic [POS_W-1:0] top
    );
        return (p == top) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (capacity >= BYTE_W'(RING_MAX - 1)) begin
            ecap = POS_W'(RING_MAX - 1);
        end else begin
            ecap = POS_W'(capacity);
        end
        rs       = CNT_W'(ecap) + 1'b1;
        used_now = used_of(rd_pos_reg, wr_pos_reg, rs);

        peek_idx = IDX_W'(rd_pos_reg) + IDX_W'(item.offset) + 1'b1;
        if (peek_idx >= IDX_W'(rs)) begin
            peek_idx = peek_idx - IDX_W'(rs);
        end

        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        hit_next    = 1'b0;
        over_next   = 1'b0;
        mem_we      = 1'b0;
        rd_addr     = peek_idx[POS_W-1:0];

        case (item.opcode)
            OP_PUSH: begin
                if ((used_now == ecap) && (used_now != '0)) begin
                    rd_pos_next = adv(rd_pos_reg, ecap);
                    over_next   = 1'b1;
                end
                wr_pos_next = adv(wr_pos_reg, ecap);
                mem_we      = 1'b1;
            end
            OP_POP: begin
                if (used_now != '0) begin
                    rd_pos_next = adv(rd_pos_reg, ecap);
                    hit_next    = 1'b1;
                end
                rd_addr = adv(rd_pos_reg, ecap);
            end
            OP_PEEK: begin
                hit_next = (IDX_W'(item.offset) < IDX_W'(used_now));
            end
            OP_CLEAR: begin
                rd_pos_next = wr_pos_reg;
            end
            default: begin
                rd_pos_next = rd_pos_reg;
            end
        endcase

        used_next = used_of(rd_pos_next, wr_pos_next, rs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            rd_pos_reg <= '0;
            wr_pos_reg <= '0;
        end else if (step) begin
            rd_pos_reg <= rd_pos_next;
            wr_pos_reg <= wr_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && mem_we) begin
            slot_mem[wr_pos_next] <= item.value;
        end
        if (step) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            hit_reg   <= hit_next;
            used_reg  <= used_next;
            empty_reg <= (used_next == '0);
            full_reg  <= (used_next == ecap);
            over_reg  <= over_next;
        end
    end

    always_comb begin
        result.data       = hit_reg ? rd_data_reg : '0;
        result.data_valid = hit_reg;
        result.used_count = BYTE_W'(used_reg);
        result.is_empty   = empty_reg;
        result.is_full    = full_reg;
        result.overwrote  = over_reg;
    end

endmodule
`default_nettype wire

// File: src/overwriting_byte_ring_fifo_unit.sv
// Top level of the overwriting byte ring FIFO with stream ports and capacity register.
`default_nettype none
// Byte FIFO in a ring of capacity+1 slots that overwrites its oldest byte when a
// push arrives while full. Each input transaction carries an opcode (push, pop,
// peek at an offset, clear) and returns exactly one result transaction with the
// data byte, a data-valid flag, the used count and the empty, full and overwrite
// flags. One transaction is taken in every cycle unless the result port stalls;
// a result passes the input register and then the result register that also
// captures the single store read port. Write the capacity register only while no
// transaction is in flight; the write empties the FIFO.
module overwriting_byte_ring_fifo_unit
    import obrf_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // value[7:0], offset[15:8]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // data[7:0], used_count[15:8], is_empty[16],
                                             // is_full[17], overwrote[18], zero[23:19]
    output logic [0:0]       m_axis_tuser    // data_valid[0]
);

    logic              in_valid_reg, in_valid_next;
    item_t             item_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] cap_reg;
    logic              advance;
    logic              step;
    logic              s_fire;
    result_t           result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = step || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= 8'd255;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.opcode <= s_axis_tuser;
            item_reg.value  <= s_axis_tdata[7:0];
            item_reg.offset <= s_axis_tdata[15:8];
        end
    end

    obrf_ring #(
        .SLOTS(SLOTS)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .capacity (cap_reg),
        .step     (step),
        .item     (item_reg),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, result.overwrote, result.is_full, result.is_empty,
                            result.used_count, result.data};
    assign m_axis_tuser  = result.data_valid;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while result stage empty");

    a_overwrite_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[17] && !m_axis_tdata[16]))
        else $error("overwrite reported without a full FIFO");

    a_reset_clears_out: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
